// ----- design/bcss_pkg.sv -----
// shared constants and types for the box coordinate step smoother
`default_nettype none
package bcss_pkg;

  localparam int CoordBitsDef   = 12;
  localparam int FracBitsDef    = 8;
  localparam int StepDivisorDef = 5;
  localparam int NumLanes       = 4;

  // configuration register indexes
  localparam int RegSmoothEnable = 0;

  typedef enum logic [1:0] {
    PosKeep,
    PosAdvance,
    PosSeed
  } pos_sel_e;

  typedef enum logic [1:0] {
    StepKeep,
    StepNew,
    StepClear
  } step_sel_e;

  // per coordinate findings of one lane
  typedef struct packed {
    logic differs;
    logic pos_zero;
    logic new_nz;
    logic step_nz;
    logic ahead;
  } lane_stat_t;

  // state update decided by the merge stage
  typedef struct packed {
    logic      tgt_upd;
    pos_sel_e  pos_sel;
    step_sel_e step_sel;
    logic      use_adv;
  } merge_ctrl_t;

endpackage
`default_nettype wire

// ----- design/bcss_lane.sv -----
// one coordinate lane: distance, step division, advance and rounding
`default_nettype none
module bcss_lane
  import bcss_pkg::*;
#(
  parameter int COORD_BITS   = CoordBitsDef,
  parameter int FRAC_BITS    = FracBitsDef,
  parameter int STEP_DIVISOR = StepDivisorDef
) (
  input  logic signed [COORD_BITS-1:0]           tgt_i,
  input  logic signed [COORD_BITS-1:0]           last_i,
  input  logic signed [COORD_BITS+FRAC_BITS-1:0] pos_i,
  input  logic signed [COORD_BITS+FRAC_BITS-1:0] step_i,
  input  logic                                   changed_i,
  output lane_stat_t                             stat_o,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] step_new_o,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] seed_o,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] adv_o,
  output logic signed [COORD_BITS-1:0]           rnd_o
);

  localparam int P          = COORD_BITS + FRAC_BITS;
  localparam int RecipShift = P + $clog2(STEP_DIVISOR);
  localparam int ProdW      = 2 * P + 1 + RecipShift;
  localparam longint unsigned RecipFull =
    ((64'd1 << RecipShift) + 64'(STEP_DIVISOR) - 64'd1) / STEP_DIVISOR;
  localparam logic [P:0] RecipM = RecipFull[P:0];

  logic signed [P:0]     delta;
  logic [P:0]            delta_neg;
  logic [P-1:0]          mag;
  logic [ProdW-1:0]      prod;
  logic [P-1:0]          quo;
  logic [P:0]            step_w;
  logic signed [P-1:0]   step_use;
  logic [P:0]            sum_w;
  logic [P-1:0]          adv;
  logic [COORD_BITS-1:0] qi;
  logic                  inc;
  logic [COORD_BITS:0]   rnd_w;

  assign seed_o    = {tgt_i, {FRAC_BITS{1'b0}}};
  assign delta     = {seed_o[P-1], seed_o} - {pos_i[P-1], pos_i};
  assign delta_neg = -delta;
  // magnitude stays below 2^P
  assign mag       = delta[P] ? delta_neg[P-1:0] : delta[P-1:0];

  // exact floor division by the constant through a rounded-up reciprocal
  assign prod = ProdW'(mag) * ProdW'(RecipM);
  assign quo  = prod[RecipShift +: P];

  always_comb begin
    if (delta[P]) begin
      step_w = -{1'b0, quo};
    end else begin
      step_w = {1'b0, quo};
    end
  end

  // saturate to the position range
  assign step_new_o = (step_w[P] != step_w[P-1]) ? {step_w[P], {(P-1){~step_w[P]}}}
                                                 : step_w[P-1:0];

  assign step_use = changed_i ? step_new_o : step_i;
  assign sum_w    = {pos_i[P-1], pos_i} + {step_use[P-1], step_use};
  assign adv      = (sum_w[P] != sum_w[P-1]) ? {sum_w[P], {(P-1){~sum_w[P]}}}
                                             : sum_w[P-1:0];
  assign adv_o    = adv;

  // round half to even, only upward overflow is possible
  assign qi    = adv[P-1:FRAC_BITS];
  assign inc   = adv[FRAC_BITS-1] & ((|adv[FRAC_BITS-2:0]) | qi[0]);
  assign rnd_w = {qi[COORD_BITS-1], qi} + {{COORD_BITS{1'b0}}, inc};
  assign rnd_o = (rnd_w[COORD_BITS] != rnd_w[COORD_BITS-1])
                 ? {rnd_w[COORD_BITS], {(COORD_BITS-1){~rnd_w[COORD_BITS]}}}
                 : rnd_w[COORD_BITS-1:0];

  assign stat_o.differs  = (tgt_i != last_i);
  assign stat_o.pos_zero = (pos_i == '0);
  assign stat_o.new_nz   = (step_new_o != '0);
  assign stat_o.step_nz  = (step_i != '0);
  assign stat_o.ahead    = (delta != '0) && (step_i != '0) && (delta[P] == step_i[P-1]);

endmodule
`default_nettype wire

// ----- design/bcss_merge.sv -----
// merge stage: combines lane findings into the state update
`default_nettype none
module bcss_merge
  import bcss_pkg::*;
(
  input  logic        enable_i,
  input  lane_stat_t  stat_i [NumLanes],
  output logic        changed_o,
  output merge_ctrl_t ctrl_o
);

  logic any_diff;
  logic all_pos;
  logic all_new_nz;
  logic all_step_nz;
  logic all_ahead;

  always_comb begin
    any_diff    = 1'b0;
    all_pos     = 1'b1;
    all_new_nz  = 1'b1;
    all_step_nz = 1'b1;
    all_ahead   = 1'b1;
    for (int i = 0; i < NumLanes; i++) begin
      any_diff    = any_diff | stat_i[i].differs;
      all_pos     = all_pos & ~stat_i[i].pos_zero;
      all_new_nz  = all_new_nz & stat_i[i].new_nz;
      all_step_nz = all_step_nz & stat_i[i].step_nz;
      all_ahead   = all_ahead & stat_i[i].ahead;
    end
  end

  assign changed_o = enable_i & any_diff;

  always_comb begin
    ctrl_o.tgt_upd  = 1'b0;
    ctrl_o.pos_sel  = PosKeep;
    ctrl_o.step_sel = StepKeep;
    ctrl_o.use_adv  = 1'b0;
    if (enable_i) begin
      if (any_diff) begin
        ctrl_o.tgt_upd = 1'b1;
        if (all_pos) begin
          if (all_new_nz) begin
            ctrl_o.step_sel = StepNew;
            ctrl_o.pos_sel  = PosAdvance;
            ctrl_o.use_adv  = 1'b1;
          end else begin
            ctrl_o.step_sel = StepClear;
          end
        end else begin
          ctrl_o.pos_sel = PosSeed;
        end
      end else if (all_step_nz) begin
        if (all_ahead) begin
          ctrl_o.pos_sel = PosAdvance;
          ctrl_o.use_adv = 1'b1;
        end else begin
          ctrl_o.step_sel = StepClear;
        end
      end else begin
        ctrl_o.pos_sel  = PosSeed;
        ctrl_o.step_sel = StepClear;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/box_coordinate_step_smoother.sv -----
// top level of the box coordinate step smoother
// the result sits in the output register the cycle after accept
// throughput: one transaction per cycle unless in_stall_o is high, set by the state
//   update through each lane's reciprocal divider and the merge stage, all combinational
// reset: positions, steps and last targets clear to zero, smooth_enable to one,
//   output register empty
`default_nettype none
module box_coordinate_step_smoother
  import bcss_pkg::*;
#(
  parameter int COORD_BITS   = CoordBitsDef,
  parameter int FRAC_BITS    = FracBitsDef,
  parameter int STEP_DIVISOR = StepDivisorDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] left_x_i,
  input  logic signed [COORD_BITS-1:0] top_y_i,
  input  logic signed [COORD_BITS-1:0] right_x_i,
  input  logic signed [COORD_BITS-1:0] bottom_y_i,
  input  logic                         face_found_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] out_left_x_o,
  output logic signed [COORD_BITS-1:0] out_top_y_o,
  output logic signed [COORD_BITS-1:0] out_right_x_o,
  output logic signed [COORD_BITS-1:0] out_bottom_y_o,
  output logic                         out_found_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int P = COORD_BITS + FRAC_BITS;

  logic                         smooth_en_q;
  logic signed [COORD_BITS-1:0] last_q [NumLanes];
  logic signed [P-1:0]          pos_q  [NumLanes];
  logic signed [P-1:0]          step_q [NumLanes];

  logic signed [COORD_BITS-1:0] tgt      [NumLanes];
  lane_stat_t                   stat     [NumLanes];
  logic signed [P-1:0]          step_new [NumLanes];
  logic signed [P-1:0]          seed     [NumLanes];
  logic signed [P-1:0]          adv      [NumLanes];
  logic signed [COORD_BITS-1:0] rnd      [NumLanes];

  logic                         changed;
  merge_ctrl_t                  ctrl;
  logic                         accept;

  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] res_q [NumLanes];
  logic                         found_q;

  assign tgt[0] = left_x_i;
  assign tgt[1] = top_y_i;
  assign tgt[2] = right_x_i;
  assign tgt[3] = bottom_y_i;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    bcss_lane #(
      .COORD_BITS  (COORD_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .STEP_DIVISOR(STEP_DIVISOR)
    ) u_lane (
      .tgt_i     (tgt[g]),
      .last_i    (last_q[g]),
      .pos_i     (pos_q[g]),
      .step_i    (step_q[g]),
      .changed_i (changed),
      .stat_o    (stat[g]),
      .step_new_o(step_new[g]),
      .seed_o    (seed[g]),
      .adv_o     (adv[g]),
      .rnd_o     (rnd[g])
    );
  end

  bcss_merge u_merge (
    .enable_i (smooth_en_q),
    .stat_i   (stat),
    .changed_o(changed),
    .ctrl_o   (ctrl)
  );

  // output register frees up in the same cycle it is taken
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (32'(paddr[2]) == RegSmoothEnable) begin
      prdata[0] = smooth_en_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_en_q <= 1'b1;
    end else if (psel && penable && pwrite && pready
                 && 32'(paddr[2]) == RegSmoothEnable) begin
      smooth_en_q <= pwdata[0];
    end
  end

  // tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLanes; i++) begin
        last_q[i] <= '0;
        pos_q[i]  <= '0;
        step_q[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < NumLanes; i++) begin
        if (ctrl.tgt_upd) begin
          last_q[i] <= tgt[i];
        end
        case (ctrl.pos_sel)
          PosAdvance: pos_q[i] <= adv[i];
          PosSeed:    pos_q[i] <= seed[i];
          default:    pos_q[i] <= pos_q[i];
        endcase
        case (ctrl.step_sel)
          StepNew:   step_q[i] <= step_new[i];
          StepClear: step_q[i] <= '0;
          default:   step_q[i] <= step_q[i];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < NumLanes; i++) begin
        res_q[i] <= ctrl.use_adv ? rnd[i] : tgt[i];
      end
      found_q <= face_found_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_left_x_o   = res_q[0];
  assign out_top_y_o    = res_q[1];
  assign out_right_x_o  = res_q[2];
  assign out_bottom_y_o = res_q[3];
  assign out_found_o    = found_q;

endmodule
`default_nettype wire
